>>> rtl/rarenv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rarenv_pkg
// Shared types and constants of the rumble attack/release envelope block.
// ----------------------------------------------------------------------------
package rarenv_pkg;

	// Field widths fixed by the item format
	localparam int ELAPSED_W   = 16;
	localparam int POWER_W     = 8;
	localparam int FIELD_LEN_W = 12;
	localparam int PROD_W      = 24;
	localparam int STEP_CNT_W  = 3;

	localparam logic [STEP_CNT_W-1:0] LAST_STEP = 3'd7;

	// Request command codes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// Register word index of motor_enable
	localparam logic REG_IDX_MOTOR_ENABLE = 1'b0;

	// Controller to datapath commands
	typedef struct packed {
		logic start_load;
		logic tick_load;
		logic mul_step;
		logic div_load;
		logic div_step;
		logic out_load;
	} rarenv_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic active;
	} rarenv_stat_t;

endpackage

>>> rtl/rumble_attack_release_envelope.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rumble_attack_release_envelope
// Attack/release envelope generator for a rumble motor, with a one-bit
// enable register on an APB-style port.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  in       | in_valid / in_ready    | cmd, power, attack_frames, release_frames
//  out      | out_valid / out_ready  | motor_on, strength
//  cfg      | psel/penable/pwrite    | paddr, pwdata, prdata (motor_enable)
//
// A start request gives no result. A tick inside the envelope runs 8
// shift-add multiply steps, one divider load and 8 restoring divide steps
// before the result load; a tick past the envelope goes straight to it. A
// new request is taken once the result is in the output register, which
// holds it while out_ready is low. Reset clears FSM, envelope and enable state.
// ----------------------------------------------------------------------------
module rumble_attack_release_envelope
	import rarenv_pkg::*;
#(
	parameter int DURATION_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   cmd,
	input  logic [POWER_W-1:0]     power,
	input  logic [FIELD_LEN_W-1:0] attack_frames,
	input  logic [FIELD_LEN_W-1:0] release_frames,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   motor_on,
	output logic [POWER_W-1:0]     strength,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	rarenv_cmd_t  ctl;
	rarenv_stat_t stat;
	logic         motor_enable_q;

	// Register port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_IDX_MOTOR_ENABLE) ? {31'b0, motor_enable_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_enable_q <= 1'b0;
		end else if (psel && penable && pwrite && pready
				&& (paddr[2] == REG_IDX_MOTOR_ENABLE)) begin
			motor_enable_q <= pwdata[0];
		end
	end

	rarenv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	rarenv_dp #(
		.DURATION_BITS (DURATION_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.stat           (stat),
		.motor_enable   (motor_enable_q),
		.power          (power),
		.attack_frames  (attack_frames),
		.release_frames (release_frames),
		.motor_on       (motor_on),
		.strength       (strength)
	);

	// A tick keeps the block busy in the cycle after it is taken
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (cmd == CMD_TICK)) |=> !in_ready)
		else $error("tick request did not occupy the block");

	// A start request never produces a result
	a_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (cmd == CMD_START)) |=> !$rose(out_valid))
		else $error("start request produced a result");

	// Attack strength stays strictly below full scale
	a_attack_below_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && motor_on) |-> (strength != {POWER_W{1'b1}}))
		else $error("attack strength reached full scale");

endmodule

>>> rtl/rarenv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rarenv_ctrl
// Sequencer: accepts requests, steps the shared multiply and divide, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module rarenv_ctrl
	import rarenv_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         cmd,
	output logic         out_valid,
	input  logic         out_ready,
	input  rarenv_stat_t stat,
	output rarenv_cmd_t  ctl
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DLOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic                  out_valid_q;
	logic                  accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Decode commands from state
	always_comb begin
		ctl            = '0;
		ctl.start_load = accept && (cmd == CMD_START);
		ctl.tick_load  = accept && (cmd == CMD_TICK);
		ctl.mul_step   = (state_q == ST_MUL);
		ctl.div_load   = (state_q == ST_DLOAD);
		ctl.div_step   = (state_q == ST_DIV);
		ctl.out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	// Hold state, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Raise valid on a load, drop it once the result is taken
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (ctl.tick_load) begin
						state_q <= stat.active ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_STEP) begin
						state_q <= ST_DLOAD;
					end
				end
				ST_DLOAD: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_STEP) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (ctl.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/rarenv_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rarenv_dp
// Envelope state, phase decode, shift-add multiplier, restoring divider
// and the result register.
// ----------------------------------------------------------------------------
module rarenv_dp
	import rarenv_pkg::*;
#(
	parameter int DURATION_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rarenv_cmd_t            ctl,
	output rarenv_stat_t           stat,
	input  logic                   motor_enable,
	input  logic [POWER_W-1:0]     power,
	input  logic [FIELD_LEN_W-1:0] attack_frames,
	input  logic [FIELD_LEN_W-1:0] release_frames,
	output logic                   motor_on,
	output logic [POWER_W-1:0]     strength
);

	logic [ELAPSED_W-1:0]     elapsed_q;
	logic [POWER_W-1:0]       peak_q;
	logic [DURATION_BITS-1:0] attack_q;
	logic [DURATION_BITS-1:0] release_q;

	logic                     attack_flag_q;
	logic [PROD_W-1:0]        mcand_q;
	logic [POWER_W-1:0]       mplier_q;
	logic [PROD_W-1:0]        acc_q;
	logic [ELAPSED_W-1:0]     dvsr_q;
	logic [PROD_W-1:0]        dsh_q;
	logic [POWER_W-1:0]       quot_q;
	logic                     motor_on_q;
	logic [POWER_W-1:0]       strength_q;

	logic [ELAPSED_W-1:0]     a_in16;
	logic [ELAPSED_W-1:0]     r_in16;
	logic [ELAPSED_W-1:0]     a16;
	logic [ELAPSED_W-1:0]     r16;
	logic [ELAPSED_W:0]       t17;
	logic [ELAPSED_W:0]       sum17;
	logic [ELAPSED_W:0]       next17;
	logic                     in_attack;
	logic                     in_window;
	logic [ELAPSED_W-1:0]     left16;
	logic [ELAPSED_W-1:0]     operand;
	logic [ELAPSED_W-1:0]     divisor;
	logic [ELAPSED_W-1:0]     elapsed_nxt;

	// Widen new lengths so the mask to DURATION_BITS is a plain slice
	assign a_in16 = ELAPSED_W'(attack_frames);
	assign r_in16 = ELAPSED_W'(release_frames);

	// Decode phase from the elapsed value before the tick
	assign a16       = ELAPSED_W'(attack_q);
	assign r16       = ELAPSED_W'(release_q);
	assign t17       = {1'b0, elapsed_q};
	assign sum17     = {1'b0, a16} + {1'b0, r16};
	assign in_attack = (t17 < {1'b0, a16});
	assign in_window = (t17 < sum17);
	assign left16    = ELAPSED_W'(sum17 - t17);
	assign operand   = in_attack ? elapsed_q : left16;
	assign divisor   = in_attack ? a16 : r16;

	// Advance elapsed by two inside the envelope, by one after it, saturating
	assign next17      = t17 + (in_window ? 17'd2 : 17'd1);
	assign elapsed_nxt = next17[ELAPSED_W] ? {ELAPSED_W{1'b1}} : next17[ELAPSED_W-1:0];

	assign stat.active = in_window;

	// Hold envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			peak_q    <= '0;
			attack_q  <= '0;
			release_q <= '0;
		end else if (ctl.start_load) begin
			elapsed_q <= '0;
			peak_q    <= power;
			attack_q  <= a_in16[DURATION_BITS-1:0];
			release_q <= r_in16[DURATION_BITS-1:0];
		end else if (ctl.tick_load) begin
			elapsed_q <= elapsed_nxt;
		end
	end

	// Multiply power by the offset, then divide by the phase length
	always_ff @(posedge clk) begin
		if (ctl.tick_load) begin
			attack_flag_q <= in_attack;
			mcand_q       <= PROD_W'(operand);
			mplier_q      <= peak_q;
			acc_q         <= '0;
			dvsr_q        <= divisor;
			quot_q        <= '0;
		end
		if (ctl.mul_step) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[POWER_W-1:1]};
		end
		if (ctl.div_load) begin
			dsh_q <= PROD_W'({dvsr_q, {(POWER_W-1){1'b0}}});
		end
		if (ctl.div_step) begin
			if (acc_q >= dsh_q) begin
				acc_q  <= acc_q - dsh_q;
				quot_q <= {quot_q[POWER_W-2:0], 1'b1};
			end else begin
				quot_q <= {quot_q[POWER_W-2:0], 1'b0};
			end
			dsh_q <= {1'b0, dsh_q[PROD_W-1:1]};
		end
	end

	// Load the result register, gated by the enable
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			motor_on_q <= motor_enable && attack_flag_q;
			strength_q <= motor_enable ? quot_q : '0;
		end
	end

	assign motor_on = motor_on_q;
	assign strength = strength_q;

endmodule
